// File: rtl/aetr_pkg.sv
package aetr_pkg;

   // defaults handed to the top level
   localparam int TAB_STOP_DEFAULT  = 8;
   localparam int ROW_COUNT_DEFAULT = 4096;
   localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

   // fixed field widths of a result word
   localparam int ROW_OUT_W = 12;

   // control bytes
   localparam logic [7:0] CH_SUB      = 8'h1a;
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_LF       = 8'h0a;
   localparam logic [7:0] CH_CR       = 8'h0d;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;
   localparam logic [7:0] CH_SEMI     = 8'h3b;
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7a;

   // command letters
   localparam logic [7:0] CMD_SGR     = 8'h6d; // m
   localparam logic [7:0] CMD_POS_H   = 8'h48; // H
   localparam logic [7:0] CMD_POS_F   = 8'h66; // f
   localparam logic [7:0] CMD_UP      = 8'h41; // A
   localparam logic [7:0] CMD_DOWN    = 8'h42; // B
   localparam logic [7:0] CMD_RIGHT   = 8'h43; // C
   localparam logic [7:0] CMD_LEFT    = 8'h44; // D
   localparam logic [7:0] CMD_SAVE    = 8'h73; // s
   localparam logic [7:0] CMD_RESTORE = 8'h75; // u
   localparam logic [7:0] CMD_CLR_SCR = 8'h4a; // J
   localparam logic [7:0] CMD_CLR_LN  = 8'h4b; // K

   // attribute bits
   localparam logic [7:0] ATTR_RESET   = 8'h07;
   localparam logic [7:0] ATTR_BOLD    = 8'h08;
   localparam logic [7:0] ATTR_BLINK   = 8'h80;
   localparam logic [7:0] ATTR_KEEP_BG = 8'hf8;
   localparam logic [7:0] ATTR_KEEP_FG = 8'h8f;

   localparam logic [15:0] PARAM_MAX = 16'hffff;

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_BRACKET,
      MODE_PARAMS,
      MODE_DONE
   } mode_type;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_CLEAR_LINE,
      OP_CLEAR_SCREEN
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [ROW_OUT_W-1:0]   row;
      logic [7:0]             col;
      logic [7:0]             char_code;
      logic [7:0]             attr;
      logic                   last;
   } result_type;

   // ANSI colour order to cell colour order (bit reversal of the index)
   function automatic logic [2:0] cell_colour(input logic [2:0] ansi);
      logic [2:0] c;
      case (ansi)
         3'd0: c = 3'd0;
         3'd1: c = 3'd4;
         3'd2: c = 3'd2;
         3'd3: c = 3'd6;
         3'd4: c = 3'd1;
         3'd5: c = 3'd5;
         3'd6: c = 3'd3;
         3'd7: c = 3'd7;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [15:0] v);
      logic [7:0] r;
      logic [2:0] fg;
      logic [2:0] bg;
      fg = 3'(v - 16'd30);
      bg = 3'(v - 16'd40);
      r  = a;
      if (v == 16'd0) begin
         r = ATTR_RESET;
      end else if (v == 16'd1) begin
         r = a | ATTR_BOLD;
      end else if (v == 16'd5) begin
         r = a | ATTR_BLINK;
      end else if (v >= 16'd30 && v <= 16'd37) begin
         r = (a & ATTR_KEEP_BG) | {5'd0, cell_colour(fg)};
      end else if (v >= 16'd40 && v <= 16'd47) begin
         r = (a & ATTR_KEEP_FG) | {1'b0, cell_colour(bg), 4'd0};
      end
      return r;
   endfunction

endpackage

// File: rtl/aetr_engine.sv
module aetr_engine #(
   parameter int TAB_STOP  = aetr_pkg::TAB_STOP_DEFAULT,
   parameter int ROW_COUNT = aetr_pkg::ROW_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   input  logic [7:0]             line_width,
   output aetr_pkg::result_type   res,
   output logic                   emit,
   output logic                   done
);

   localparam int RowW  = $clog2(ROW_COUNT);
   localparam int LeftW = $clog2(TAB_STOP);
   localparam int CntW  = $clog2(TAB_STOP + 1);
   localparam int TabRecip = (65536 + TAB_STOP - 1) / TAB_STOP;
   localparam logic [RowW-1:0] RowMax   = RowW'(ROW_COUNT - 1);
   localparam logic [16:0]     RowMax17 = 17'(ROW_COUNT - 1);

   aetr_pkg::mode_type mode_ff, mode_in;
   logic [7:0]      col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [7:0]      attr_ff, attr_in;
   logic [7:0]      saved_col_ff, saved_col_in;
   logic [RowW-1:0] saved_row_ff, saved_row_in;
   logic [15:0]     first_ff, first_in;
   logic [15:0]     second_ff, second_in;
   logic [15:0]     cur_ff, cur_in;
   logic [1:0]      count_ff, count_in;
   logic            open_ff, open_in;
   logic [7:0]      pend_ff, pend_in;
   logic            multi_ff, multi_in;
   logic [LeftW-1:0] left_ff, left_in;
   logic [7:0]      fill_ff, fill_in;

   // helpers
   logic [7:0]      width;
   logic [8:0]      col_p1;
   logic            wrap;
   logic [RowW-1:0] row_inc;
   logic [7:0]      adv_col;
   logic [RowW-1:0] adv_row;
   logic [24:0]     tab_prod;
   logic [7:0]      tab_q;
   logic [7:0]      tab_rem;
   logic [CntW-1:0] tab_cnt;
   logic            is_letter;
   logic            is_digit;
   logic [19:0]     digit_sum;
   logic [15:0]     a1, a2, n, a2n, a2m1, nm1;
   logic [RowW-1:0] room;
   logic [16:0]     right_sum;
   logic [7:0]      width_m1;

   assign width    = (line_width == 8'd0) ? 8'd1 : line_width;
   assign width_m1 = width - 8'd1;

   // put-cell cursor advance with wrap
   assign col_p1  = {1'b0, col_ff} + 9'd1;
   assign wrap    = col_p1 >= {1'b0, width};
   assign row_inc = (row_ff == RowMax) ? RowMax : row_ff + RowW'(1);
   assign adv_col = wrap ? 8'd0 : col_p1[7:0];
   assign adv_row = wrap ? row_inc : row_ff;

   // column modulo tab stop by reciprocal multiply
   assign tab_prod = 25'(col_ff) * 25'(TabRecip);
   assign tab_q    = tab_prod[23:16];
   assign tab_rem  = col_ff - 8'(tab_q * 8'(TAB_STOP));
   assign tab_cnt  = CntW'(TAB_STOP) - CntW'(tab_rem);

   assign is_letter = (in_byte >= aetr_pkg::CH_UPPER_A && in_byte <= aetr_pkg::CH_UPPER_Z) ||
                      (in_byte >= aetr_pkg::CH_LOWER_A && in_byte <= aetr_pkg::CH_LOWER_Z);
   assign is_digit  = in_byte >= aetr_pkg::CH_DIGIT_0 && in_byte <= aetr_pkg::CH_DIGIT_9;
   assign digit_sum = {1'b0, cur_ff, 3'd0} + {3'd0, cur_ff, 1'b0}
                    + 20'(in_byte - aetr_pkg::CH_DIGIT_0);

   // command arguments
   assign a1   = (count_ff == 2'd0) ? cur_ff : first_ff;
   assign a2   = (count_ff == 2'd0) ? 16'd0 : ((count_ff == 2'd1) ? cur_ff : second_ff);
   assign n    = (a1 == 16'd0) ? 16'd1 : a1;
   assign nm1  = n - 16'd1;
   assign a2n  = (a2 == 16'd0) ? 16'd1 : a2;
   assign a2m1 = a2n - 16'd1;
   assign room = RowMax - row_ff;
   assign right_sum = 17'(col_ff) + 17'(n);

   always_comb begin
      mode_in      = mode_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      attr_in      = attr_ff;
      saved_col_in = saved_col_ff;
      saved_row_in = saved_row_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      open_in      = open_ff;
      pend_in      = pend_ff;
      multi_in     = multi_ff;
      left_in      = left_ff;
      fill_in      = fill_ff;
      emit         = 1'b0;
      done         = 1'b1;
      res.op        = aetr_pkg::OP_WRITE;
      res.row       = aetr_pkg::ROW_OUT_W'(row_ff);
      res.col       = col_ff;
      res.char_code = in_byte;
      res.attr      = attr_ff;

      if (multi_ff) begin
         // rest of a tab burst or of an ESC pair
         emit          = 1'b1;
         res.char_code = fill_ff;
         col_in        = adv_col;
         row_in        = adv_row;
         left_in       = left_ff - LeftW'(1);
         done          = left_ff == LeftW'(1);
         multi_in      = !done;
      end else begin
         case (mode_ff)
            aetr_pkg::MODE_TEXT: begin
               if (in_byte == aetr_pkg::CH_SUB) begin
                  mode_in = aetr_pkg::MODE_DONE;
               end else if (in_byte == aetr_pkg::CH_ESC) begin
                  mode_in = aetr_pkg::MODE_BRACKET;
               end else if (in_byte == aetr_pkg::CH_LF) begin
                  row_in = row_inc;
                  col_in = 8'd0;
               end else if (in_byte == aetr_pkg::CH_CR) begin
                  mode_in = mode_ff;
               end else if (in_byte == aetr_pkg::CH_TAB) begin
                  emit          = 1'b1;
                  res.char_code = aetr_pkg::CH_SPACE;
                  col_in        = adv_col;
                  row_in        = adv_row;
                  if (tab_cnt != CntW'(1)) begin
                     multi_in = 1'b1;
                     left_in  = LeftW'(tab_cnt - CntW'(1));
                     fill_in  = aetr_pkg::CH_SPACE;
                     done     = 1'b0;
                  end
               end else begin
                  emit   = 1'b1;
                  col_in = adv_col;
                  row_in = adv_row;
               end
            end
            aetr_pkg::MODE_BRACKET: begin
               if (in_byte != aetr_pkg::CH_LBRACKET) begin
                  // lone ESC: write it and the byte after it as cells
                  emit          = 1'b1;
                  res.char_code = aetr_pkg::CH_ESC;
                  col_in        = adv_col;
                  row_in        = adv_row;
                  multi_in      = 1'b1;
                  left_in       = LeftW'(1);
                  fill_in       = in_byte;
                  done          = 1'b0;
                  mode_in       = aetr_pkg::MODE_TEXT;
               end else begin
                  mode_in   = aetr_pkg::MODE_PARAMS;
                  first_in  = 16'd0;
                  second_in = 16'd0;
                  cur_in    = 16'd0;
                  count_in  = 2'd0;
                  open_in   = 1'b1;
                  pend_in   = attr_ff;
               end
            end
            aetr_pkg::MODE_PARAMS: begin
               if (is_letter) begin
                  mode_in = aetr_pkg::MODE_TEXT;
                  case (in_byte)
                     aetr_pkg::CMD_SGR: begin
                        attr_in = aetr_pkg::sgr_apply(pend_ff, cur_ff);
                     end
                     aetr_pkg::CMD_POS_H, aetr_pkg::CMD_POS_F: begin
                        row_in = ({1'b0, nm1} > RowMax17) ? RowMax : RowW'(nm1);
                        col_in = (a2m1 > 16'(width_m1)) ? width_m1 : a2m1[7:0];
                     end
                     aetr_pkg::CMD_UP: begin
                        row_in = (17'(n) >= 17'(row_ff)) ? '0 : row_ff - RowW'(n);
                     end
                     aetr_pkg::CMD_DOWN: begin
                        row_in = (17'(n) >= 17'(room)) ? RowMax : row_ff + RowW'(n);
                     end
                     aetr_pkg::CMD_RIGHT: begin
                        col_in = (right_sum > 17'(width_m1)) ? width_m1 : right_sum[7:0];
                     end
                     aetr_pkg::CMD_LEFT: begin
                        col_in = (17'(n) >= 17'(col_ff)) ? 8'd0 : col_ff - 8'(n);
                     end
                     aetr_pkg::CMD_SAVE: begin
                        saved_col_in = col_ff;
                        saved_row_in = row_ff;
                     end
                     aetr_pkg::CMD_RESTORE: begin
                        col_in = saved_col_ff;
                        row_in = saved_row_ff;
                     end
                     aetr_pkg::CMD_CLR_SCR: begin
                        emit          = 1'b1;
                        res.op        = aetr_pkg::OP_CLEAR_SCREEN;
                        res.row       = '0;
                        res.col       = 8'd0;
                        res.char_code = aetr_pkg::CH_SPACE;
                        res.attr      = aetr_pkg::ATTR_RESET;
                        row_in        = '0;
                     end
                     aetr_pkg::CMD_CLR_LN: begin
                        emit          = 1'b1;
                        res.op        = aetr_pkg::OP_CLEAR_LINE;
                        res.char_code = aetr_pkg::CH_SPACE;
                     end
                     default: begin
                        mode_in = aetr_pkg::MODE_TEXT;
                     end
                  endcase
               end else if (in_byte == aetr_pkg::CH_SEMI) begin
                  if (count_ff == 2'd0) begin
                     first_in = cur_ff;
                  end else if (count_ff == 2'd1) begin
                     second_in = cur_ff;
                  end
                  pend_in = aetr_pkg::sgr_apply(pend_ff, cur_ff);
                  cur_in  = 16'd0;
                  open_in = 1'b1;
                  if (count_ff != 2'd3) begin
                     count_in = count_ff + 2'd1;
                  end
               end else if (is_digit && open_ff) begin
                  cur_in = (digit_sum > 20'(aetr_pkg::PARAM_MAX)) ? aetr_pkg::PARAM_MAX
                                                                   : digit_sum[15:0];
               end else begin
                  open_in = 1'b0;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
      res.last = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= aetr_pkg::MODE_TEXT;
         col_ff       <= 8'd0;
         row_ff       <= '0;
         attr_ff      <= aetr_pkg::ATTR_RESET;
         saved_col_ff <= 8'd0;
         saved_row_ff <= '0;
         first_ff     <= 16'd0;
         second_ff    <= 16'd0;
         cur_ff       <= 16'd0;
         count_ff     <= 2'd0;
         open_ff      <= 1'b1;
         pend_ff      <= aetr_pkg::ATTR_RESET;
         multi_ff     <= 1'b0;
         left_ff      <= '0;
         fill_ff      <= 8'd0;
      end else if (step) begin
         mode_ff      <= mode_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         saved_col_ff <= saved_col_in;
         saved_row_ff <= saved_row_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         open_ff      <= open_in;
         pend_ff      <= pend_in;
         multi_ff     <= multi_in;
         left_ff      <= left_in;
         fill_ff      <= fill_in;
      end
   end

endmodule

// File: rtl/aetr_rsp_buf.sv
module aetr_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  aetr_pkg::result_type   res_in,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output aetr_pkg::result_type   res_out,
   output logic                   free
);

   logic                 valid_ff, valid_in;
   aetr_pkg::result_type res_ff;

   // a word leaves on the same edge a new one may enter
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign res_out   = res_ff;

endmodule

// File: rtl/ansi_escape_text_renderer.sv
// channel  | direction | handshake                 | word
// ---------+-----------+---------------------------+--------------------------------------
// req_     | in        | req_valid / req_stall     | in_byte
// rsp_     | out       | rsp_valid / rsp_stall     | op, row, col, char_code, attr, last
// csr_     | in        | csr_valid / csr_ready     | line_width
//
// One byte a cycle in steady state, while rsp_stall is low and each byte causes at
// most one result. A byte stays in the input register until all its results have
// gone to the result register: a tab causes up to TAB_STOP, a lone ESC pair two.
// Synchronous active-high reset: cursor home, attribute 7, text mode, width 80.
// rsp_stall holds the result register; the input register then stalls req_ only
// once its byte actually needs that register.
module ansi_escape_text_renderer #(
   parameter int TAB_STOP  = aetr_pkg::TAB_STOP_DEFAULT,
   parameter int ROW_COUNT = aetr_pkg::ROW_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   // screen operations out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_op,
   output logic [11:0] rsp_row,
   output logic [7:0]  rsp_col,
   output logic [7:0]  rsp_char_code,
   output logic [7:0]  rsp_attr,
   output logic        rsp_last,
   // line width register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_line_width
);

   logic [7:0]           width_ff;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           byte_ff;
   logic                 accept;
   logic                 fire;
   logic                 emit;
   logic                 done;
   logic                 out_free;
   aetr_pkg::result_type res_next;
   aetr_pkg::result_type res_out;

   // the user must make config writes only while idle; the block does not enforce it, so always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= aetr_pkg::LINE_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_line_width;
      end
   end

   // a step runs when a byte is held and its result (if any) has somewhere to go
   assign fire      = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !(fire && done);
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !(fire && done));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
      end
   end

   aetr_engine #(
      .TAB_STOP  (TAB_STOP),
      .ROW_COUNT (ROW_COUNT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (fire),
      .in_byte    (byte_ff),
      .line_width (width_ff),
      .res        (res_next),
      .emit       (emit),
      .done       (done)
   );

   aetr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .res_in    (res_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .res_out   (res_out),
      .free      (out_free)
   );

   assign rsp_op        = res_out.op;
   assign rsp_row       = res_out.row;
   assign rsp_col       = res_out.col;
   assign rsp_char_code = res_out.char_code;
   assign rsp_attr      = res_out.attr;
   assign rsp_last      = res_out.last;

endmodule

// File: tb/render_checker.sv
`timescale 1ns / 1ps

module render_checker #(
   parameter int TAB_STOP  = aetr_pkg::TAB_STOP_DEFAULT,
   parameter int ROW_COUNT = aetr_pkg::ROW_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_op,
   input  logic [11:0] rsp_row,
   input  logic [7:0]  rsp_col,
   input  logic [7:0]  rsp_char_code,
   input  logic [7:0]  rsp_attr,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_line_width,
   output int          error_count,
   output int          outstanding
);

   import aetr_pkg::*;

   mode_type    mode_now;
   logic [7:0]  width_reg;
   logic [7:0]  col_pos;
   logic [15:0] row_pos;
   logic [7:0]  attr_now;
   logic [7:0]  attr_pending;
   logic [7:0]  saved_col;
   logic [15:0] saved_row;
   logic [15:0] arg0;
   logic [15:0] arg1;
   logic [15:0] arg_acc;
   logic [1:0]  arg_count;
   logic        digits_on;
   result_type  cell_ops_due[$];
   int          mismatches = 0;

   function automatic int cols();
      return (width_reg == 8'd0) ? 1 : int'(width_reg);
   endfunction

   // ANSI colour index to cell colour index is a bit reversal
   function automatic logic [2:0] hue(input logic [2:0] ansi);
      return {ansi[0], ansi[1], ansi[2]};
   endfunction

   function automatic logic [7:0] sgr_update(input logic [7:0] a, input logic [15:0] v);
      logic [15:0] fg_i;
      logic [15:0] bg_i;
      fg_i = v - 16'd30;
      bg_i = v - 16'd40;
      if (v == 16'd0) return ATTR_RESET;
      if (v == 16'd1) return a | ATTR_BOLD;
      if (v == 16'd5) return a | ATTR_BLINK;
      if (v >= 16'd30 && v <= 16'd37) return {a[7:3], hue(fg_i[2:0])};
      if (v >= 16'd40 && v <= 16'd47) return {a[7], hue(bg_i[2:0]), a[3:0]};
      return a;
   endfunction

   task automatic queue_op(input op_type op, input logic [15:0] row, input logic [7:0] col,
                           input logic [7:0] ch, input logic [7:0] attr);
      result_type r;
      r.op        = op;
      r.row       = row[ROW_OUT_W-1:0];
      r.col       = col;
      r.char_code = ch;
      r.attr      = attr;
      r.last      = 1'b0;
      cell_ops_due.push_back(r);
   endtask

   task automatic rows_down(input int n);
      int room;
      room = ROW_COUNT - 1 - int'(row_pos);
      row_pos = (n >= room) ? 16'(ROW_COUNT - 1) : 16'(int'(row_pos) + n);
   endtask

   task automatic write_cell(input logic [7:0] ch);
      int next_col;
      queue_op(OP_WRITE, row_pos, col_pos, ch, attr_now);
      next_col = int'(col_pos) + 1;
      if (next_col >= cols()) begin
         col_pos = '0;
         rows_down(1);
      end else begin
         col_pos = 8'(next_col);
      end
   endtask

   // expected screen words for one accepted input byte
   task automatic render_byte(input logic [7:0] b);
      int         queued_at_start;
      int         a1;
      int         a2;
      int         n;
      int         w;
      int         acc;
      int         k;
      result_type tail;
      queued_at_start = cell_ops_due.size();
      case (mode_now)
         MODE_TEXT: begin
            if (b == CH_SUB) begin
               mode_now = MODE_DONE;
            end else if (b == CH_ESC) begin
               mode_now = MODE_BRACKET;
            end else if (b == CH_LF) begin
               rows_down(1);
               col_pos = '0;
            end else if (b == CH_CR) begin
               // carriage return leaves the cursor alone
            end else if (b == CH_TAB) begin
               for (k = TAB_STOP - int'(col_pos) % TAB_STOP; k > 0; k--) write_cell(CH_SPACE);
            end else begin
               write_cell(b);
            end
         end
         MODE_BRACKET: begin
            if (b != CH_LBRACKET) begin
               write_cell(CH_ESC);
               write_cell(b);
               mode_now = MODE_TEXT;
            end else begin
               mode_now     = MODE_PARAMS;
               arg0         = '0;
               arg1         = '0;
               arg_acc      = '0;
               arg_count    = '0;
               digits_on    = 1'b1;
               attr_pending = attr_now;
            end
         end
         MODE_PARAMS: begin
            if ((b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z)) begin
               a1 = (arg_count == 2'd0) ? int'(arg_acc) : int'(arg0);
               a2 = (arg_count == 2'd0) ? 0 : (arg_count == 2'd1) ? int'(arg_acc) : int'(arg1);
               n  = (a1 == 0) ? 1 : a1;
               w  = cols();
               case (b)
                  CMD_SGR: attr_now = sgr_update(attr_pending, arg_acc);
                  CMD_POS_H, CMD_POS_F: begin
                     row_pos = (n - 1 > ROW_COUNT - 1) ? 16'(ROW_COUNT - 1) : 16'(n - 1);
                     if (a2 == 0) a2 = 1;
                     col_pos = (a2 - 1 > w - 1) ? 8'(w - 1) : 8'(a2 - 1);
                  end
                  CMD_UP: row_pos = (n >= int'(row_pos)) ? '0 : 16'(int'(row_pos) - n);
                  CMD_DOWN: rows_down(n);
                  CMD_RIGHT: begin
                     col_pos = (int'(col_pos) + n > w - 1) ? 8'(w - 1) : 8'(int'(col_pos) + n);
                  end
                  CMD_LEFT: col_pos = (n >= int'(col_pos)) ? '0 : 8'(int'(col_pos) - n);
                  CMD_SAVE: begin
                     saved_col = col_pos;
                     saved_row = row_pos;
                  end
                  CMD_RESTORE: begin
                     col_pos = saved_col;
                     row_pos = saved_row;
                  end
                  CMD_CLR_SCR: begin
                     queue_op(OP_CLEAR_SCREEN, '0, '0, CH_SPACE, ATTR_RESET);
                     row_pos = '0;
                  end
                  CMD_CLR_LN: queue_op(OP_CLEAR_LINE, row_pos, col_pos, CH_SPACE, attr_now);
                  default: ;
               endcase
               mode_now = MODE_TEXT;
            end else if (b == CH_SEMI) begin
               if (arg_count == 2'd0) arg0 = arg_acc;
               else if (arg_count == 2'd1) arg1 = arg_acc;
               attr_pending = sgr_update(attr_pending, arg_acc);
               arg_acc      = '0;
               digits_on    = 1'b1;
               if (arg_count < 2'd3) arg_count = arg_count + 2'd1;
            end else if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9 && digits_on) begin
               acc     = int'(arg_acc) * 10 + int'(b - CH_DIGIT_0);
               arg_acc = (acc > int'(PARAM_MAX)) ? PARAM_MAX : 16'(acc);
            end else begin
               digits_on = 1'b0;
            end
         end
         default: ; // after CTRL-Z the stream is dead
      endcase
      if (cell_ops_due.size() > queued_at_start) begin
         tail      = cell_ops_due.pop_back();
         tail.last = 1'b1;
         cell_ops_due.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         mode_now     = MODE_TEXT;
         width_reg    = LINE_WIDTH_RESET;
         col_pos      = '0;
         row_pos      = '0;
         attr_now     = ATTR_RESET;
         attr_pending = ATTR_RESET;
         saved_col    = '0;
         saved_row    = '0;
         arg0         = '0;
         arg1         = '0;
         arg_acc      = '0;
         arg_count    = '0;
         digits_on    = 1'b1;
         cell_ops_due.delete();
      end else begin
         // results first: a byte taken at this edge cannot answer at this edge
         if (rsp_valid && !rsp_stall) begin
            got.op        = op_type'(rsp_op);
            got.row       = rsp_row;
            got.col       = rsp_col;
            got.char_code = rsp_char_code;
            got.attr      = rsp_attr;
            got.last      = rsp_last;
            if (cell_ops_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected word: op/row/col/char/attr/last %0d/%0d/%0d/%h/%h/%0b",
                           got.op, got.row, got.col, got.char_code, got.attr, got.last);
               mismatches++;
            end else begin
               want = cell_ops_due.pop_front();
               if (got !== want) begin
                  // fields: op/row/col/char/attr/last
                  if (mismatches < 10)
                     $display("mismatch: want %0d/%0d/%0d/%h/%h/%0b got %0d/%0d/%0d/%h/%h/%0b",
                              want.op, want.row, want.col, want.char_code, want.attr,
                              want.last, got.op, got.row, got.col, got.char_code, got.attr,
                              got.last);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) width_reg = csr_line_width;
         if (req_valid && !req_stall) render_byte(req_in_byte);
      end
      outstanding = cell_ops_due.size();
      error_count = mismatches;
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   import aetr_pkg::*;

   // a tab is the longest byte: eight words, plus a little pipeline slack
   localparam int SETTLE_CYCLES = 24;
   // receiver hold-off long enough for the input side to back up
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_ITEMS   = 46;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic [7:0]  req_in_byte    = '0;
   logic        rsp_stall      = 1'b0;
   logic        csr_valid      = 1'b0;
   logic [7:0]  csr_line_width = LINE_WIDTH_RESET;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_op;
   logic [11:0] rsp_row;
   logic [7:0]  rsp_col;
   logic [7:0]  rsp_char_code;
   logic [7:0]  rsp_attr;
   logic        rsp_last;
   logic        csr_ready;

   int error_count;
   int outstanding;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;
   int bytes_sent     = 0;

   // opening stream at the reset width: plain cells, a byte with every bit set,
   // tab, CR, LF, an ESC not followed by '[', a full SGR with four parameters
   // (bold, red, blue background, blink; the count reaches its top value), then K and J
   logic [7:0] opening_text [25] = '{
      8'h41, 8'hff, CH_TAB, CH_CR, CH_LF,
      CH_ESC, 8'h71,
      CH_ESC, CH_LBRACKET, 8'h31, CH_SEMI, 8'h33, 8'h31, CH_SEMI,
      8'h34, 8'h34, CH_SEMI, 8'h35, CMD_SGR,
      CH_ESC, CH_LBRACKET, CMD_CLR_LN,
      CH_ESC, CH_LBRACKET, CMD_CLR_SCR
   };

   always #10 clock = ~clock;

   ansi_escape_text_renderer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_op         (rsp_op),
      .rsp_row        (rsp_row),
      .rsp_col        (rsp_col),
      .rsp_char_code  (rsp_char_code),
      .rsp_attr       (rsp_attr),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_line_width (csr_line_width)
   );

   render_checker screen_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_op         (rsp_op),
      .rsp_row        (rsp_row),
      .rsp_col        (rsp_col),
      .rsp_char_code  (rsp_char_code),
      .rsp_attr       (rsp_attr),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_line_width (csr_line_width),
      .error_count    (error_count),
      .outstanding    (outstanding)
   );

   // Receiver: random stall each cycle, or one long hold-off when asked.
   // The hold is counted here so the sender keeps pushing meanwhile.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Offer one byte and hold it until the block takes it. Called just after a
   // rising edge; returns just after the edge that accepted the word.
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic write_width(input logic [7:0] w);
      csr_valid      <= 1'b1;
      csr_line_width <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Drain: every expected word seen, then let the pipe clear with no byte offered.
   // outstanding is read on the falling edge, away from the checker's update.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
   endfunction

   // One random unit of stream. Mostly text and complete CSI sequences with
   // random content; some ESC pairs, junk inside parameters and broken
   // sequences. CTRL-Z is never sent in text mode here: it would end the run.
   task automatic send_sequence();
      int         kind;
      int         r;
      int         nparams;
      int         k;
      int         v;
      int         nd;
      int         d;
      int         digs [8];
      logic [7:0] b;
      kind = $urandom_range(99);
      if (kind < 40) begin
         r = $urandom_range(9);
         if (r == 0) b = CH_TAB;
         else if (r == 1) b = CH_LF;
         else if (r == 2) b = CH_CR;
         else begin
            do b = 8'($urandom_range(255)); while (b == CH_SUB || b == CH_ESC);
         end
         send_byte(b);
      end else if (kind < 50) begin
         // ESC then anything but '[' lands as two cells
         send_byte(CH_ESC);
         do b = 8'($urandom_range(255)); while (b == CH_LBRACKET);
         send_byte(b);
      end else begin
         send_byte(CH_ESC);
         send_byte(CH_LBRACKET);
         nparams = (kind >= 95) ? 0 : int'($urandom_range(4));
         for (k = 0; k < nparams; k++) begin
            r = $urandom_range(9);
            if (r < 5) begin
               case ($urandom_range(4))
                  0: v = 0;
                  1: v = 1;
                  2: v = 5;
                  3: v = 30 + int'($urandom_range(7));
                  default: v = 40 + int'($urandom_range(7));
               endcase
            end else if (r < 8) begin
               v = $urandom_range(300);
            end else if (r == 8) begin
               v = -1; // empty parameter
            end else begin
               v = $urandom_range(9_999_999, 60_000); // saturates at 65535
            end
            if (v >= 0) begin
               nd = 0;
               do begin
                  digs[nd] = v % 10;
                  v        = v / 10;
                  nd++;
               end while (v > 0);
               for (d = nd - 1; d >= 0; d--) send_byte(CH_DIGIT_0 + 8'(digs[d]));
            end
            // non-letter junk; unless it is a digit or ';', it closes digit entry for this parameter
            if ($urandom_range(7) == 0) begin
               do b = 8'($urandom_range(255)); while (is_letter(b));
               send_byte(b);
            end
            if (k < nparams - 1) send_byte(CH_SEMI);
         end
         if (kind >= 95) begin
            repeat ($urandom_range(4, 1)) begin
               do b = 8'($urandom_range(255)); while (is_letter(b));
               send_byte(b);
            end
         end
         if ($urandom_range(9) == 0) begin
            do b = 8'($urandom_range(255)); while (!is_letter(b));
         end else begin
            case ($urandom_range(10))
               0: b = CMD_SGR;
               1: b = CMD_POS_H;
               2: b = CMD_POS_F;
               3: b = CMD_UP;
               4: b = CMD_DOWN;
               5: b = CMD_RIGHT;
               6: b = CMD_LEFT;
               7: b = CMD_SAVE;
               8: b = CMD_RESTORE;
               9: b = CMD_CLR_SCR;
               default: b = CMD_CLR_LN;
            endcase
         end
         send_byte(b);
      end
   endtask

   task automatic run_phase(input logic [7:0] w, input int idle_pct, input int stall_pct);
      int goal;
      write_width(w);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      goal           = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < goal) send_sequence();
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed stream at the reset width
      foreach (opening_text[i]) send_byte(opening_text[i]);
      wait_idle();

      // widest line, no idling, with one long receiver hold-off up front
      hold_request = 1'b1;
      run_phase(8'd255, 0, 0);
      // one column: every cell wraps; sender mostly idle
      run_phase(8'd1, 86, 0);
      // zero width behaves as one; receiver mostly stalling
      run_phase(8'd0, 0, 86);
      // some width in between, light idling on both sides
      run_phase(8'($urandom_range(254, 2)), 13, 13);

      // CTRL-Z in text mode, then bytes that must all be ignored
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_byte(CH_SUB);
      send_byte(CH_ESC);
      send_byte(CH_LBRACKET);
      send_byte(CMD_CLR_SCR);
      repeat (4) send_byte(8'($urandom_range(255)));
      wait_idle();

      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
